[rtl/icodib_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the icon bitmap decoder.
package icodib_pkg;

	// Largest image side accepted, in pixels.
	localparam int unsigned MAX_SIDE = 512;
	// Bits that hold any count from 0 up to MAX_SIDE.
	localparam int unsigned SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam logic [31:0] MAX_SIDE32 = 32'(MAX_SIDE);

	// Header layout and acceptance rules.
	localparam logic [31:0] HDR_MIN  = 32'd40;
	localparam logic [15:0] DEPTH_OK = 16'd32;
	localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;

	// Result field widths.
	localparam int unsigned POS_W = 9;
	localparam int unsigned DIM_W = 10;

	// Depth of the queue between front and back.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_HDR   = 3'd2,
		ST_FMT   = 3'd3,
		ST_DIM   = 3'd4,
		ST_TRUNC = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_blob;
	} req_t;

	typedef struct packed {
		logic             is_final;
		logic [2:0]       status;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       alpha;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} res_t;

	// One queue entry: the results that one byte causes, a pixel and/or the status.
	typedef struct packed {
		logic             has_pix;
		logic             has_fin;
		status_t          status;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       alpha;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} entry_t;

endpackage

[rtl/ico_dib_bgra_to_rgba_decoder.sv]
`timescale 1ns / 1ps
// Icon-entry bitmap decoder: takes one blob byte per request and emits RGBA pixels and a status.
//
// Each request carries one byte of a bare bitmap info header followed by
// bottom-up B,G,R,A pixel data; end_of_blob marks the last byte. The parser
// assembles header size, width, height, bit depth and compression, accepts
// only 32-bit uncompressed images of side 1..512 (height is half the stored
// height), and from byte offset header_size emits every fourth byte a pixel
// result with its top-down row and column. The last byte of a blob yields a
// status result (0 ok, 1 short, 2 header size, 3 format, 4 dimensions,
// 5 truncated); drop the pixels of that blob if it is nonzero. Bytes after
// the image (the mask) are ignored. One request is taken every cycle while
// full is low: full rises only when the four-entry queue between parser and
// result stage is full, which happens only when pop is held off. The result
// stage hands out one result per cycle while pop is high, so the last byte
// of a blob, which may cause both a pixel and the status, yields them one
// after the other. A result passes through the queue memory and then the
// result register. No clearing pass is needed after reset.
module ico_dib_bgra_to_rgba_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  icodib_pkg::req_t     request,
	output logic                 empty,
	input  logic                 pop,
	output icodib_pkg::res_t     result
);

	logic               wr_en;
	icodib_pkg::entry_t wr_entry;
	logic               q_empty;
	logic               rd_en;
	icodib_pkg::entry_t rd_entry;

	// Front: parse bytes and queue the results they cause
	icodib_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.q_full   (full),
		.wr_en    (wr_en),
		.wr_entry (wr_entry)
	);

	// Decouple parser from the result side
	icodib_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.full     (full),
		.q_empty  (q_empty),
		.rd_en    (rd_en),
		.rd_entry (rd_entry)
	);

	// Back: hold the oldest result until popped
	icodib_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.rd_entry (rd_entry),
		.rd_en    (rd_en),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	// A pixel always lies inside the image it belongs to
	a_pix_col: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.is_final) |-> ({1'b0, result.col} < result.width))
		else $error("pixel column outside image width");

	a_pix_row: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.is_final) |-> ({1'b0, result.row} < result.height))
		else $error("pixel row outside image height");

	// Pixel results always carry the ok status
	a_pix_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.is_final) |-> (result.status == icodib_pkg::ST_OK))
		else $error("pixel result with nonzero status");

	// Whenever the queue is full the result stage holds a result
	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full while no result is offered");

endmodule

[rtl/icodib_front.sv]
`timescale 1ns / 1ps
// Byte parser: assembles the header, tracks pixel position and queues result entries.
module icodib_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  icodib_pkg::req_t     request,
	input  logic                 q_full,
	output logic                 wr_en,
	output icodib_pkg::entry_t   wr_entry
);

	logic [31:0]                     byte_count_q;
	logic [31:0]                     hdr_size_q;
	logic [31:0]                     raw_width_q;
	logic [31:0]                     raw_height_q;
	logic [15:0]                     bit_depth_q;
	logic [31:0]                     compression_q;
	logic [1:0]                      byte_in_pixel_q;
	logic [icodib_pkg::SIDE_W-1:0]   pixel_col_q;
	logic [icodib_pkg::SIDE_W-1:0]   stored_row_q;
	logic [23:0]                     held_q;
	logic                            image_complete_q;

	logic                            accept;
	logic                            sat;
	logic [31:0]                     bc_next;
	logic [30:0]                     ih;
	logic                            dims_ok;
	logic                            fmt_ok;
	logic                            hdr_big;
	logic                            hdr_ok;
	logic                            pix_go;
	logic                            pix_done;
	logic [icodib_pkg::SIDE_W-1:0]   width_n;
	logic [icodib_pkg::SIDE_W-1:0]   ih_n;
	logic [icodib_pkg::SIDE_W-1:0]   col_inc;
	logic [icodib_pkg::SIDE_W-1:0]   row_inc;
	logic [icodib_pkg::SIDE_W-1:0]   row_top;
	logic                            row_wrap;
	logic                            complete_next;
	logic                            show_dims;
	icodib_pkg::status_t             status;

	always_comb begin
		accept   = push && !q_full;
		sat      = (byte_count_q == icodib_pkg::CNT_MAX);
		bc_next  = sat ? byte_count_q : byte_count_q + 32'd1;
		ih       = raw_height_q[31:1];
		dims_ok  = !raw_width_q[31] && !raw_height_q[31] &&
			(raw_width_q != 32'd0) && (raw_width_q <= icodib_pkg::MAX_SIDE32) &&
			(ih != 31'd0) && ({1'b0, ih} <= icodib_pkg::MAX_SIDE32);
		fmt_ok   = (bit_depth_q == icodib_pkg::DEPTH_OK) && (compression_q == 32'd0);
		hdr_big  = (hdr_size_q >= icodib_pkg::HDR_MIN);
		hdr_ok   = hdr_big && fmt_ok && dims_ok;
		width_n  = raw_width_q[icodib_pkg::SIDE_W-1:0];
		ih_n     = ih[icodib_pkg::SIDE_W-1:0];
		pix_go   = !sat && (byte_count_q >= hdr_size_q) && !image_complete_q && hdr_ok;
		pix_done = pix_go && (byte_in_pixel_q == 2'd3);
		col_inc  = pixel_col_q + 1'b1;
		row_inc  = stored_row_q + 1'b1;
		row_top  = ih_n - 1'b1 - stored_row_q;
		row_wrap = (col_inc >= width_n);
		complete_next = image_complete_q || (pix_done && row_wrap && (row_inc >= ih_n));

		// Status checks in priority order
		if (bc_next < icodib_pkg::HDR_MIN) begin
			status = icodib_pkg::ST_SHORT;
		end else if (!hdr_big) begin
			status = icodib_pkg::ST_HDR;
		end else if (!fmt_ok) begin
			status = icodib_pkg::ST_FMT;
		end else if (!dims_ok) begin
			status = icodib_pkg::ST_DIM;
		end else if (complete_next) begin
			status = icodib_pkg::ST_OK;
		end else begin
			status = icodib_pkg::ST_TRUNC;
		end
		show_dims = pix_done || (status == icodib_pkg::ST_OK) ||
			(status == icodib_pkg::ST_TRUNC);

		wr_en            = accept && (pix_done || request.end_of_blob);
		wr_entry.has_pix = pix_done;
		wr_entry.has_fin = request.end_of_blob;
		wr_entry.status  = status;
		wr_entry.col     = icodib_pkg::POS_W'(pixel_col_q);
		wr_entry.row     = icodib_pkg::POS_W'(row_top);
		wr_entry.red     = held_q[23:16];
		wr_entry.green   = held_q[15:8];
		wr_entry.blue    = held_q[7:0];
		wr_entry.alpha   = request.data_byte;
		wr_entry.width   = show_dims ? raw_width_q[icodib_pkg::DIM_W-1:0] : '0;
		wr_entry.height  = show_dims ? ih[icodib_pkg::DIM_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= '0;
			hdr_size_q       <= '0;
			raw_width_q      <= '0;
			raw_height_q     <= '0;
			bit_depth_q      <= '0;
			compression_q    <= '0;
			byte_in_pixel_q  <= '0;
			pixel_col_q      <= '0;
			stored_row_q     <= '0;
			held_q           <= '0;
			image_complete_q <= 1'b0;
		end else if (accept) begin
			if (request.end_of_blob) begin
				// Blob done: start the next one from scratch
				byte_count_q     <= '0;
				hdr_size_q       <= '0;
				raw_width_q      <= '0;
				raw_height_q     <= '0;
				bit_depth_q      <= '0;
				compression_q    <= '0;
				byte_in_pixel_q  <= '0;
				pixel_col_q      <= '0;
				stored_row_q     <= '0;
				held_q           <= '0;
				image_complete_q <= 1'b0;
			end else begin
				byte_count_q <= bc_next;
				// Little-endian header lanes
				if (byte_count_q < 32'd20) begin
					case (byte_count_q[4:0]) inside
						[5'd0:5'd3]: begin
							hdr_size_q[{byte_count_q[1:0], 3'b000} +: 8] <= request.data_byte;
						end
						[5'd4:5'd7]: begin
							raw_width_q[{byte_count_q[1:0], 3'b000} +: 8] <= request.data_byte;
						end
						[5'd8:5'd11]: begin
							raw_height_q[{byte_count_q[1:0], 3'b000} +: 8] <= request.data_byte;
						end
						[5'd14:5'd15]: begin
							bit_depth_q[{byte_count_q[0], 3'b000} +: 8] <= request.data_byte;
						end
						[5'd16:5'd19]: begin
							compression_q[{byte_count_q[1:0], 3'b000} +: 8] <= request.data_byte;
						end
						default: begin
						end
					endcase
				end
				if (pix_go) begin
					if (!pix_done) begin
						held_q[{byte_in_pixel_q, 3'b000} +: 8] <= request.data_byte;
						byte_in_pixel_q <= byte_in_pixel_q + 2'd1;
					end else begin
						held_q          <= '0;
						byte_in_pixel_q <= '0;
						if (row_wrap) begin
							pixel_col_q  <= '0;
							stored_row_q <= row_inc;
						end else begin
							pixel_col_q <= col_inc;
						end
						image_complete_q <= complete_next;
					end
				end
			end
		end
	end

endmodule

[rtl/icodib_queue.sv]
`timescale 1ns / 1ps
// Short entry queue between the byte parser and the result stage.
module icodib_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  icodib_pkg::entry_t   wr_entry,
	output logic                 full,
	output logic                 q_empty,
	input  logic                 rd_en,
	output icodib_pkg::entry_t   rd_entry
);

	icodib_pkg::entry_t            mem_q [icodib_pkg::QDEPTH];
	logic [icodib_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [icodib_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [icodib_pkg::QCNT_W-1:0] count_q;
	logic                          do_wr;
	logic                          do_rd;

	function automatic logic [icodib_pkg::QPTR_W-1:0] ptr_adv(
		input logic [icodib_pkg::QPTR_W-1:0] ptr);
		return (ptr == icodib_pkg::QPTR_W'(icodib_pkg::QDEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_comb begin
		full     = (count_q == icodib_pkg::QCNT_W'(icodib_pkg::QDEPTH));
		q_empty  = (count_q == '0);
		do_wr    = wr_en && !full;
		do_rd    = rd_en && !q_empty;
		rd_entry = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_adv(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_adv(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/icodib_back.sv]
`timescale 1ns / 1ps
// Result stage: holds one entry and hands out its pixel, then its status.
module icodib_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  icodib_pkg::entry_t   rd_entry,
	output logic                 rd_en,
	input  logic                 pop,
	output logic                 empty,
	output icodib_pkg::res_t     result
);

	icodib_pkg::entry_t cur_q;
	logic               cur_valid_q;
	logic               pix_pend_q;
	logic               take;
	logic               keep;

	always_comb begin
		empty = !cur_valid_q;
		take  = pop && cur_valid_q;
		// Pixel popped but the status of the same byte still waits
		keep  = pix_pend_q && cur_q.has_fin;
		rd_en = !q_empty && (!cur_valid_q || (take && !keep));

		result.width  = cur_q.width;
		result.height = cur_q.height;
		if (pix_pend_q) begin
			result.is_final = 1'b0;
			result.status   = icodib_pkg::ST_OK;
			result.col      = cur_q.col;
			result.row      = cur_q.row;
			result.red      = cur_q.red;
			result.green    = cur_q.green;
			result.blue     = cur_q.blue;
			result.alpha    = cur_q.alpha;
		end else begin
			result.is_final = 1'b1;
			result.status   = cur_q.status;
			result.col      = '0;
			result.row      = '0;
			result.red      = '0;
			result.green    = '0;
			result.blue     = '0;
			result.alpha    = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_q <= rd_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pix_pend_q  <= 1'b0;
		end else if (rd_en) begin
			cur_valid_q <= 1'b1;
			pix_pend_q  <= rd_entry.has_pix;
		end else if (take) begin
			if (keep) begin
				pix_pend_q <= 1'b0;
			end else begin
				cur_valid_q <= 1'b0;
				pix_pend_q  <= 1'b0;
			end
		end
	end

endmodule
